// File: design/token_bucket_fairness_policer_core_assert.svh
// Assertion macros shared by the policer RTL.
// No dependencies; taken in by `include in the modules that assert.
`ifndef TOKEN_BUCKET_FAIRNESS_POLICER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_FAIRNESS_POLICER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TBFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TBFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tbfp_pkg.sv
// Package for the token bucket fairness policer: widths, codes, state and
// command types. No dependencies.
`timescale 1ns / 1ps

package tbfp_pkg;

	localparam int NUM_FLOWS = 64;
	localparam int FLOW_AW   = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;

	localparam int FLOW_W     = 6;
	localparam int TICK_W     = 32;
	localparam int BYTES_W    = 14;
	localparam int RATE_W     = 32;
	localparam int CAP_W      = 24;
	localparam int FAIR_W     = 17;
	localparam int FRAC_W     = 16;
	localparam int LEVEL_W    = CAP_W + FRAC_W;
	localparam int GAIN_W     = TICK_W + RATE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [FAIR_W-1:0] FAIR_ONE = 17'h10000;

	localparam logic [FAIR_W-1:0] THRESHOLD_RST  = 17'd13107;
	localparam logic [FAIR_W-1:0] GREEN_STEP_RST = 17'd66;
	localparam logic [FAIR_W-1:0] RED_STEP_RST   = 17'd655;
	localparam logic [FAIR_W-1:0] FAIR_START_RST = 17'd0;

	localparam logic ACTION_LOAD   = 1'b0;
	localparam logic ACTION_PACKET = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_DROP   = 2'd0,
		VERDICT_GREEN  = 2'd1,
		VERDICT_RED    = 2'd2,
		VERDICT_LOADED = 2'd3
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD  = 2'd0,
		CFG_GREEN_STEP = 2'd1,
		CFG_RED_STEP   = 2'd2,
		CFG_FAIR_START = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [FAIR_W-1:0] threshold;
		logic [FAIR_W-1:0] green_step;
		logic [FAIR_W-1:0] red_step;
		logic [FAIR_W-1:0] fair_start;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [TICK_W-1:0]  last_tick;
		logic [FAIR_W-1:0]  fairness;
		logic [RATE_W-1:0]  rate;
		logic [CAP_W-1:0]   capacity;
	} flow_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ACCRUE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic mul;
		logic accrue;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// File: design/tbfp_if.sv
// Valid/ready channel interfaces for the policer's input and result words.
// Depends on tbfp_pkg.
`timescale 1ns / 1ps

interface tbfp_in_if;
	import tbfp_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic [FLOW_W-1:0]  flow_id;
	logic [TICK_W-1:0]  arrival_tick;
	logic [BYTES_W-1:0] packet_bytes;
	logic [RATE_W-1:0]  rate_in;
	logic [CAP_W-1:0]   capacity_in;

	modport source (
		output valid, action, flow_id, arrival_tick, packet_bytes, rate_in, capacity_in,
		input  ready
	);
	modport sink (
		input  valid, action, flow_id, arrival_tick, packet_bytes, rate_in, capacity_in,
		output ready
	);
endinterface

interface tbfp_out_if;
	import tbfp_pkg::*;

	logic              valid;
	logic              ready;
	verdict_t          verdict;
	logic [CAP_W-1:0]  tokens_left;
	logic [FAIR_W-1:0] fairness_now;

	modport source (
		output valid, verdict, tokens_left, fairness_now,
		input  ready
	);
	modport sink (
		input  valid, verdict, tokens_left, fairness_now,
		output ready
	);
endinterface

// File: design/tbfp_cfg.sv
// Configuration registers of the policer, written through a plain write port.
// Depends on tbfp_pkg.
`timescale 1ns / 1ps

module tbfp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tbfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tbfp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output tbfp_pkg::cfg_t                     cfg
);
	import tbfp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.green_step <= GREEN_STEP_RST;
			cfg_q.red_step   <= RED_STEP_RST;
			cfg_q.fair_start <= FAIR_START_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD:  cfg_q.threshold  <= FAIR_W'(cfg_wdata);
				CFG_GREEN_STEP: cfg_q.green_step <= FAIR_W'(cfg_wdata);
				CFG_RED_STEP:   cfg_q.red_step   <= FAIR_W'(cfg_wdata);
				CFG_FAIR_START: cfg_q.fair_start <= FAIR_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/tbfp_ctrl.sv
// Sequencing state machine of the policer: read, multiply, accrue, update.
// Depends on tbfp_pkg and token_bucket_fairness_policer_core_assert.svh.
`timescale 1ns / 1ps

`include "token_bucket_fairness_policer_core_assert.svh"

module tbfp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tbfp_pkg::dp_status_t status,
	output tbfp_pkg::dp_cmd_t    cmd
);
	import tbfp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_MUL;
			ST_MUL:    state_nxt = ST_ACCRUE;
			ST_ACCRUE: state_nxt = ST_UPDATE;
			ST_UPDATE: if (status.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_READ:   cmd.rd = 1'b1;
			ST_MUL:    cmd.mul = 1'b1;
			ST_ACCRUE: cmd.accrue = 1'b1;
			ST_UPDATE: cmd.commit = status.out_free;
			default: ;
		endcase
	end

	`TBFP_ASSERT_NEXT(a_capture_reads, clk, arst_n, cmd.capture, state_q == ST_READ, "accepted word did not start a table read")
	`TBFP_ASSERT_NEXT(a_update_holds, clk, arst_n, (state_q == ST_UPDATE) && !status.out_free, (state_q == ST_UPDATE) && !cmd.capture, "update left while result register was full")
	`TBFP_ASSERT_NEXT(a_commit_idles, clk, arst_n, cmd.commit, (state_q == ST_IDLE) && in_ready, "no return to idle after commit")

endmodule

// File: design/tbfp_dp.sv
// Datapath of the policer: flow table, token accrual, fairness update and
// result register. Depends on tbfp_pkg.
`timescale 1ns / 1ps

module tbfp_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tbfp_pkg::dp_cmd_t                cmd,
	output tbfp_pkg::dp_status_t             status,
	input  tbfp_pkg::cfg_t                   cfg,
	input  logic                             in_action,
	input  logic [tbfp_pkg::FLOW_W-1:0]      in_flow_id,
	input  logic [tbfp_pkg::TICK_W-1:0]      in_arrival_tick,
	input  logic [tbfp_pkg::BYTES_W-1:0]     in_packet_bytes,
	input  logic [tbfp_pkg::RATE_W-1:0]      in_rate,
	input  logic [tbfp_pkg::CAP_W-1:0]       in_capacity,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tbfp_pkg::verdict_t               out_verdict,
	output logic [tbfp_pkg::CAP_W-1:0]       out_tokens_left,
	output logic [tbfp_pkg::FAIR_W-1:0]      out_fairness_now
);
	import tbfp_pkg::*;

	// captured word
	logic               action_q;
	logic [FLOW_W-1:0]  flow_q;
	logic [TICK_W-1:0]  tick_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [RATE_W-1:0]  rate_q;
	logic [CAP_W-1:0]   cap_q;

	// flow table
	flow_entry_t        mem [NUM_FLOWS];
	logic [NUM_FLOWS-1:0] valid_q;
	flow_entry_t        rd_entry_q;
	logic               rd_valid_q;
	flow_entry_t        entry;

	logic [LEVEL_W-1:0] cap_full;
	logic [LEVEL_W-1:0] cap_full_q;
	logic [LEVEL_W-1:0] level_cl_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [LEVEL_W-1:0] level_acc_q;
	logic [FAIR_W-1:0]  fair_q;

	logic [TICK_W-1:0]  elapsed;
	logic [GAIN_W-1:0]  product;
	logic [GAIN_W:0]    sum;
	logic               saturate;

	logic [FLOW_AW-1:0] idx;
	logic               in_range;
	logic [LEVEL_W-1:0] need;
	logic               green;
	logic [FAIR_W:0]    f_up;
	logic [FAIR_W-1:0]  f_up_cl;
	logic [FAIR_W-1:0]  f_dn;
	logic [FAIR_W-1:0]  f_dn_cl;
	logic [FAIR_W-1:0]  f_new;
	logic [FAIR_W-1:0]  start_cl;

	logic               wr_en;
	flow_entry_t        wr_entry;
	verdict_t           res_verdict;
	logic [CAP_W-1:0]   res_tokens;
	logic [FAIR_W-1:0]  res_fair;

	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [CAP_W-1:0]   tokens_q;
	logic [FAIR_W-1:0]  fairness_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			flow_q   <= in_flow_id;
			tick_q   <= in_arrival_tick;
			bytes_q  <= in_packet_bytes;
			rate_q   <= in_rate;
			cap_q    <= in_capacity;
		end
	end

	assign idx      = FLOW_AW'(flow_q);
	assign in_range = 32'(flow_q) < 32'(NUM_FLOWS);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_entry_q <= mem[idx];
		end
		if (wr_en) begin
			mem[idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rd_valid_q <= valid_q[idx];
			end
			if (wr_en) begin
				valid_q[idx] <= 1'b1;
			end
		end
	end

	// entries never written read as zero
	assign entry    = rd_valid_q ? rd_entry_q : '0;
	assign cap_full = {entry.capacity, FRAC_W'(0)};
	assign elapsed  = tick_q - entry.last_tick;
	assign product  = elapsed * entry.rate;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			gain_q     <= product;
			cap_full_q <= cap_full;
			level_cl_q <= (entry.level > cap_full) ? cap_full : entry.level;
			fair_q     <= entry.fairness;
		end
	end

	assign sum      = (GAIN_W + 1)'(level_cl_q) + (GAIN_W + 1)'(gain_q);
	assign saturate = (gain_q >= GAIN_W'(cap_full_q)) || (sum >= (GAIN_W + 1)'(cap_full_q));

	always_ff @(posedge clk) begin
		if (cmd.accrue) begin
			level_acc_q <= saturate ? cap_full_q : sum[LEVEL_W-1:0];
		end
	end

	assign need  = LEVEL_W'({bytes_q, FRAC_W'(0)});
	assign green = level_acc_q >= need;

	assign f_up    = (FAIR_W + 1)'(fair_q) + (FAIR_W + 1)'(cfg.green_step);
	assign f_up_cl = (f_up > (FAIR_W + 1)'(FAIR_ONE)) ? FAIR_ONE : f_up[FAIR_W-1:0];
	assign f_dn    = (fair_q > cfg.red_step) ? (fair_q - cfg.red_step) : '0;
	assign f_dn_cl = (f_dn > FAIR_ONE) ? FAIR_ONE : f_dn;
	assign f_new   = green ? f_up_cl : f_dn_cl;

	assign start_cl = (cfg.fair_start > FAIR_ONE) ? FAIR_ONE : cfg.fair_start;

	always_comb begin
		wr_en       = 1'b0;
		wr_entry    = '0;
		res_verdict = VERDICT_DROP;
		res_tokens  = '0;
		res_fair    = '0;
		if (!in_range) begin
			res_verdict = (action_q == ACTION_LOAD) ? VERDICT_LOADED : VERDICT_DROP;
		end else if (action_q == ACTION_LOAD) begin
			wr_en             = cmd.commit;
			wr_entry.rate     = rate_q;
			wr_entry.capacity = cap_q;
			wr_entry.fairness = start_cl;
			res_verdict       = VERDICT_LOADED;
			res_fair          = start_cl;
		end else begin
			wr_en              = cmd.commit;
			wr_entry.level     = green ? (level_acc_q - need) : level_acc_q;
			wr_entry.last_tick = tick_q;
			wr_entry.fairness  = f_new;
			wr_entry.rate      = entry.rate;
			wr_entry.capacity  = entry.capacity;
			if (green) begin
				res_verdict = VERDICT_GREEN;
			end else if (f_new < cfg.threshold) begin
				res_verdict = VERDICT_DROP;
			end else begin
				res_verdict = VERDICT_RED;
			end
			res_tokens = wr_entry.level[LEVEL_W-1:FRAC_W];
			res_fair   = f_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q  <= res_verdict;
			tokens_q   <= res_tokens;
			fairness_q <= res_fair;
		end
	end

	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign out_verdict      = verdict_q;
	assign out_tokens_left  = tokens_q;
	assign out_fairness_now = fairness_q;

endmodule

// File: design/token_bucket_fairness_policer_core.sv
// Per-flow token bucket policer with fairness-based early drop: top level.
// Depends on tbfp_pkg, tbfp_if, tbfp_cfg, tbfp_ctrl and tbfp_dp.
//
// Use: words enter on the items channel (valid/ready); each gives exactly one
// result word on the results channel. A load word sets a flow's rate and
// capacity; a packet word is coloured green or red and admitted or dropped.
// Config registers (threshold, green step, red step, start fairness) are
// written through cfg_we/cfg_index/cfg_wdata, only while the block is idle:
// a rule for the user that the block does not enforce. Each word passes the
// read-modify-write of the single-port flow table (read, multiply, accrue,
// update) before its result is registered and a new word can be taken.
// The result register frees the input side: the next word is taken while a
// result still waits. If results stalls, the block holds in its update step
// and takes no new word until the waiting result has gone.
// Reset: config registers return to their defaults and all 64 flow entries
// read as zero at once (per-entry valid bits); no clearing pass is needed.
`timescale 1ns / 1ps

module token_bucket_fairness_policer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	tbfp_in_if.sink                          items,
	tbfp_out_if.source                       results,
	input  logic                             cfg_we,
	input  logic [tbfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbfp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import tbfp_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;

	tbfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tbfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tbfp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg              (cfg),
		.in_action        (items.action),
		.in_flow_id       (items.flow_id),
		.in_arrival_tick  (items.arrival_tick),
		.in_packet_bytes  (items.packet_bytes),
		.in_rate          (items.rate_in),
		.in_capacity      (items.capacity_in),
		.out_valid        (results.valid),
		.out_ready        (results.ready),
		.out_verdict      (results.verdict),
		.out_tokens_left  (results.tokens_left),
		.out_fairness_now (results.fairness_now)
	);

	assign items.ready = in_ready;

endmodule
